### sv/md5_pkg.sv
// Package for the MD5 digest block: command and status types, state codes,
// the round constant and shift tables, and the message word schedule.
// Used by md5_ctrl, md5_dpath and md5_message_digest; depends on nothing.
package md5_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_LEN,
    ST_EMIT
  } state_e;

  // Which block the compression unit is working on.
  typedef enum logic [1:0] {
    PH_DATA,
    PH_PAD,
    PH_FINAL
  } phase_e;

  // Block buffer write operations.
  typedef enum logic [1:0] {
    BUF_NONE,
    BUF_BYTE,
    BUF_PAD,
    BUF_LEN
  } buf_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    buf_op_e    buf_op;
    logic       cnt_inc;
    logic       comp_init;
    logic       comp_step;
    logic       fold;
    logic       restart;
    logic [1:0] word_sel;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_last;
    logic pad_two;
    logic round_last;
  } dp_status_t;

  localparam logic [1:0] LastWordIdx = 2'd3;
  localparam logic [5:0] LastRound   = 6'd63;
  localparam logic [5:0] LastBytePos = 6'd63;
  localparam logic [5:0] LenBytePos  = 6'd56;
  localparam logic [7:0] PadByte     = 8'h80;
  localparam logic [3:0] LenLoWord   = 4'd14;
  localparam logic [3:0] LenHiWord   = 4'd15;

  // Chaining words after reset and after every digest.
  localparam logic [31:0] INIT_WORDS [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  // Additive round constants.
  localparam logic [31:0] K_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left rotate amounts, indexed by {round group, step within four}.
  localparam logic [4:0] ROT_TABLE [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by a given step.
  function automatic logic [3:0] msg_index(input logic [5:0] step);
    logic [3:0] s;
    logic [3:0] r;
    s = step[3:0];
    unique case (step[5:4])
      2'd0:    r = s;
      2'd1:    r = 4'((s << 2) + s + 4'd1);
      2'd2:    r = 4'((s << 1) + s + 4'd5);
      default: r = 4'((s << 3) - s);
    endcase
    return r;
  endfunction

endpackage

### sv/md5_message_digest.sv
// MD5 digest over a byte stream, at most one byte per item. A byte that
// completes a block starts a compression (setup, 64 rounds of the single
// round unit, fold) before the next item is taken. End of message adds one
// or two padding blocks, then 4 digest items, one per cycle while the
// receiver is ready. Reset loads the initial chaining words and clears the
// byte count; the block buffer is not reset.
module md5_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] byte_valid
  input  logic        s_axis_tlast_i,   // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [1:0]  m_axis_tuser_o,   // [1:0] word_index
  output logic        m_axis_tlast_o    // last_word
);

  md5_pkg::ctrl_cmd_t  cmd;
  md5_pkg::dp_status_t sts;

  // Sequencer.
  md5_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_byte_valid_i (s_axis_tuser_i),
    .in_eom_i        (s_axis_tlast_i),
    .in_ready_o      (s_axis_tready_o),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_index_o     (m_axis_tuser_o),
    .out_last_o      (m_axis_tlast_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  // Buffer, count and compression unit.
  md5_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (s_axis_tdata_i),
    .sts_o         (sts),
    .digest_word_o (m_axis_tdata_o)
  );

endmodule

### sv/md5_ctrl.sv
// Controller of the MD5 digest block: sequences byte intake, compression,
// padding and digest output. Depends on md5_pkg for types and codes.
module md5_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_byte_valid_i,
  input  logic                  in_eom_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            out_index_o,
  output logic                  out_last_o,
  input  md5_pkg::dp_status_t   sts_i,
  output md5_pkg::ctrl_cmd_t    cmd_o
);

  md5_pkg::state_e state_q, state_d;
  md5_pkg::phase_e phase_q, phase_d;
  logic            eom_q, eom_d;
  logic [1:0]      word_q, word_d;
  logic            in_fire;

  assign in_fire = in_valid_i && (state_q == md5_pkg::ST_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      md5_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_byte_valid_i && sts_i.pos_last) begin
            state_d = md5_pkg::ST_INIT;
          end else if (in_eom_i) begin
            state_d = md5_pkg::ST_PAD;
          end
        end
      end
      md5_pkg::ST_INIT:  state_d = md5_pkg::ST_ROUND;
      md5_pkg::ST_ROUND: begin
        if (sts_i.round_last) begin
          state_d = md5_pkg::ST_FOLD;
        end
      end
      md5_pkg::ST_FOLD: begin
        unique case (phase_q)
          md5_pkg::PH_DATA:  state_d = eom_q ? md5_pkg::ST_PAD : md5_pkg::ST_IDLE;
          md5_pkg::PH_PAD:   state_d = md5_pkg::ST_LEN;
          default:           state_d = md5_pkg::ST_EMIT;
        endcase
      end
      md5_pkg::ST_PAD:   state_d = md5_pkg::ST_INIT;
      md5_pkg::ST_LEN:   state_d = md5_pkg::ST_INIT;
      md5_pkg::ST_EMIT: begin
        if (out_ready_i && (word_q == md5_pkg::LastWordIdx)) begin
          state_d = md5_pkg::ST_IDLE;
        end
      end
      default: state_d = md5_pkg::ST_IDLE;
    endcase
  end

  // Phase, end flag and output word counter.
  always_comb begin
    phase_d = phase_q;
    eom_d   = eom_q;
    word_d  = word_q;
    if (in_fire) begin
      eom_d   = in_eom_i;
      phase_d = md5_pkg::PH_DATA;
    end
    if (state_q == md5_pkg::ST_PAD) begin
      phase_d = sts_i.pad_two ? md5_pkg::PH_PAD : md5_pkg::PH_FINAL;
    end
    if (state_q == md5_pkg::ST_LEN) begin
      phase_d = md5_pkg::PH_FINAL;
    end
    if ((state_q == md5_pkg::ST_EMIT) && out_ready_i) begin
      word_d = word_q + 2'd1;
    end
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd_o          = '0;
    cmd_o.buf_op   = md5_pkg::BUF_NONE;
    cmd_o.word_sel = word_q;
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    unique case (state_q)
      md5_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_byte_valid_i) begin
          cmd_o.buf_op  = md5_pkg::BUF_BYTE;
          cmd_o.cnt_inc = 1'b1;
        end
      end
      md5_pkg::ST_INIT:  cmd_o.comp_init = 1'b1;
      md5_pkg::ST_ROUND: cmd_o.comp_step = 1'b1;
      md5_pkg::ST_FOLD:  cmd_o.fold = 1'b1;
      md5_pkg::ST_PAD:   cmd_o.buf_op = md5_pkg::BUF_PAD;
      md5_pkg::ST_LEN:   cmd_o.buf_op = md5_pkg::BUF_LEN;
      md5_pkg::ST_EMIT: begin
        out_valid_o   = 1'b1;
        cmd_o.restart = out_ready_i && (word_q == md5_pkg::LastWordIdx);
      end
      default: ;
    endcase
  end

  assign out_index_o = word_q;
  assign out_last_o  = (word_q == md5_pkg::LastWordIdx);

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= md5_pkg::ST_IDLE;
      phase_q <= md5_pkg::PH_DATA;
      eom_q   <= 1'b0;
      word_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      eom_q   <= eom_d;
      word_q  <= word_d;
    end
  end

`ifndef SYNTH
  // Input and output are never offered in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a digest item is offered");

  // A byte that completes a block starts a compression.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_byte_valid_i && sts_i.pos_last) |=> (state_q == md5_pkg::ST_INIT))
    else $error("full block not compressed");

  // The round loop runs until the last round.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == md5_pkg::ST_ROUND) && !sts_i.round_last)
      |=> (state_q == md5_pkg::ST_ROUND))
    else $error("round loop left early");

  // The digest ends only after the fourth word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> ($past(word_q) == md5_pkg::LastWordIdx))
    else $error("digest cut short");
`endif

endmodule

### sv/md5_dpath.sv
// Datapath of the MD5 digest block: block buffer, byte count, chaining
// words and the one-step-per-cycle round unit. Depends on md5_pkg.
module md5_dpath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  md5_pkg::ctrl_cmd_t    cmd_i,
  input  logic [7:0]            data_byte_i,
  output md5_pkg::dp_status_t   sts_o,
  output logic [31:0]           digest_word_o
);

  logic [31:0] buf_q [16];
  logic [31:0] buf_d [16];
  logic [31:0] chain_q [4];
  logic [60:0] count_q;
  logic [5:0]  rnd_q;
  logic [31:0] a_q, b_q, c_q, d_q, pre_q;
  logic [5:0]  pos;
  logic [63:0] bit_len;
  logic [5:0]  nxt_idx;
  logic [31:0] msg_word;
  logic [31:0] pre_d;
  logic [31:0] f_w;
  logic [31:0] sum_w;
  logic [63:0] rot_w;
  logic [31:0] new_b;
  logic [4:0]  shamt;

  assign pos     = count_q[5:0];
  assign bit_len = {count_q, 3'b000};

  assign sts_o.pos_last   = (pos == md5_pkg::LastBytePos);
  assign sts_o.pad_two    = (pos >= md5_pkg::LenBytePos);
  assign sts_o.round_last = (rnd_q == md5_pkg::LastRound);

  assign digest_word_o = chain_q[cmd_i.word_sel];

  // Block buffer writes: one byte, the padding block or the length block.
  always_comb begin
    buf_d = buf_q;
    unique case (cmd_i.buf_op)
      md5_pkg::BUF_NONE: ;
      md5_pkg::BUF_BYTE: buf_d[pos[5:2]][{pos[1:0], 3'b000} +: 8] = data_byte_i;
      md5_pkg::BUF_PAD: begin
        for (int j = 0; j < 16; j++) begin
          for (int k = 0; k < 4; k++) begin
            if ({4'(j), 2'(k)} == pos) begin
              buf_d[j][8*k +: 8] = md5_pkg::PadByte;
            end else if ({4'(j), 2'(k)} > pos) begin
              buf_d[j][8*k +: 8] = 8'h00;
            end
          end
        end
        if (!sts_o.pad_two) begin
          buf_d[md5_pkg::LenLoWord] = bit_len[31:0];
          buf_d[md5_pkg::LenHiWord] = bit_len[63:32];
        end
      end
      default: begin
        for (int j = 0; j < 16; j++) begin
          buf_d[j] = '0;
        end
        buf_d[md5_pkg::LenLoWord] = bit_len[31:0];
        buf_d[md5_pkg::LenHiWord] = bit_len[63:32];
      end
    endcase
  end

  // Next step's constant and message word, added ahead of the step.
  assign nxt_idx  = cmd_i.comp_init ? 6'd0 : rnd_q + 6'd1;
  assign msg_word = buf_q[md5_pkg::msg_index(nxt_idx)];
  assign pre_d    = (cmd_i.comp_init ? chain_q[0] : d_q)
                    + md5_pkg::K_TABLE[nxt_idx] + msg_word;

  // Round function of the current step.
  always_comb begin
    unique case (rnd_q[5:4])
      2'd0:    f_w = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f_w = (d_q & b_q) | (~d_q & c_q);
      2'd2:    f_w = b_q ^ c_q ^ d_q;
      default: f_w = c_q ^ (b_q | ~d_q);
    endcase
  end

  assign shamt = md5_pkg::ROT_TABLE[{rnd_q[5:4], rnd_q[1:0]}];
  assign sum_w = pre_q + f_w;
  assign rot_w = {sum_w, sum_w} << shamt;
  assign new_b = rot_w[63:32] + b_q;

  // Chaining words, byte count and round counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        chain_q[i] <= md5_pkg::INIT_WORDS[i];
      end
      count_q <= '0;
      rnd_q   <= '0;
    end else begin
      if (cmd_i.restart) begin
        for (int i = 0; i < 4; i++) begin
          chain_q[i] <= md5_pkg::INIT_WORDS[i];
        end
        count_q <= '0;
      end else begin
        if (cmd_i.fold) begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
        end
        if (cmd_i.cnt_inc) begin
          count_q <= count_q + 61'd1;
        end
      end
      if (cmd_i.comp_init) begin
        rnd_q <= '0;
      end else if (cmd_i.comp_step) begin
        rnd_q <= rnd_q + 6'd1;
      end
    end
  end

  // Working registers and block buffer.
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (cmd_i.comp_init) begin
      a_q   <= chain_q[0];
      b_q   <= chain_q[1];
      c_q   <= chain_q[2];
      d_q   <= chain_q[3];
      pre_q <= pre_d;
    end else if (cmd_i.comp_step) begin
      a_q   <= d_q;
      b_q   <= new_b;
      c_q   <= b_q;
      d_q   <= c_q;
      pre_q <= pre_d;
    end
  end

endmodule

### tb/md5_message_digest_tb.sv
// Self-checking testbench for md5_message_digest: byte streams in, digest words out.
// Holds its own MD5 predictor and compares every digest item with it.
// Depends only on the md5_message_digest RTL and its package.
module md5_message_digest_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The limit leaves a wide margin over the slowest correct run.
  localparam int CycleLimit = 400_000;
  localparam int TailCycles = 200;

  localparam logic [31:0] Md5Iv [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };
  localparam int RotateBy [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_e;

  // One digest item as it leaves the block.
  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] data_byte
  logic        s_axis_tuser_i;   // [0] byte_valid
  logic        s_axis_tlast_i;   // end_of_message
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // [31:0] digest_word
  logic [1:0]  m_axis_tuser_o;   // [1:0] word_index
  logic        m_axis_tlast_o;   // last_word

  // Predictor state.
  logic [31:0] round_k [64];
  logic [31:0] md5_state [4];
  logic [31:0] msg_block [16];
  logic [60:0] msg_len_bytes;
  digest_item_t digest_q [$];

  int err_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit steady_send = 1'b0;
  int hold_off_req = 0;
  int hold_left = 0;
  int mode_left = 0;
  int rx_phase = 0;
  rx_mode_e rx_mode = RX_ALWAYS;

  md5_message_digest i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 4 ns clock.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("md5_message_digest_tb: errors");
      $finish;
    end
  end

  // Back to the initial chaining words and an empty message.
  function automatic void md5_restart();
    int k;
    for (k = 0; k < 4; k++) md5_state[k] = Md5Iv[k];
    msg_len_bytes = '0;
  endfunction

  function automatic void put_msg_byte(input int pos, input logic [7:0] val);
    msg_block[pos / 4][(pos % 4) * 8 +: 8] = val;
  endfunction

  // The 64-step compression of msg_block into md5_state.
  function automatic void md5_compress();
    logic [31:0] a, b, c, d, f, sum, t;
    int i, g, rot;
    a = md5_state[0];
    b = md5_state[1];
    c = md5_state[2];
    d = md5_state[3];
    for (i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      sum = a + f + round_k[i] + msg_block[g];
      rot = RotateBy[(i / 16) * 4 + i % 4];
      t = ((sum << rot) | (sum >> (32 - rot))) + b;
      a = d;
      d = c;
      c = b;
      b = t;
    end
    md5_state[0] = md5_state[0] + a;
    md5_state[1] = md5_state[1] + b;
    md5_state[2] = md5_state[2] + c;
    md5_state[3] = md5_state[3] + d;
  endfunction

  // Absorb one accepted item; on end of message, pad and queue the digest.
  function automatic void md5_absorb(input logic [7:0] data, input logic has_byte,
                                     input logic msg_end);
    int pos, k;
    logic [63:0] bit_len;
    digest_item_t item;
    if (has_byte) begin
      put_msg_byte(int'(msg_len_bytes[5:0]), data);
      msg_len_bytes = msg_len_bytes + 61'd1;
      if (msg_len_bytes[5:0] == 6'd0) md5_compress();
    end
    if (!msg_end) return;
    pos = int'(msg_len_bytes[5:0]);
    put_msg_byte(pos, 8'h80);
    pos++;
    // No room for the length: this block is closed and a new one follows.
    if (pos > 56) begin
      while (pos < 64) begin
        put_msg_byte(pos, 8'h00);
        pos++;
      end
      md5_compress();
      pos = 0;
    end
    while (pos < 56) begin
      put_msg_byte(pos, 8'h00);
      pos++;
    end
    bit_len = {msg_len_bytes, 3'b000};
    msg_block[14] = bit_len[31:0];
    msg_block[15] = bit_len[63:32];
    md5_compress();
    for (k = 0; k < 4; k++) begin
      item.word  = md5_state[k];
      item.index = 2'(k);
      item.last  = (k == 3);
      digest_q.push_back(item);
    end
    md5_restart();
  endfunction

  // Receiver: a long hold-off on request, otherwise a changing stall pattern.
  always @(negedge clk_i) begin
    if (hold_off_req > 0) begin
      hold_left = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      rx_phase++;
      case (rx_mode)
        RX_ALWAYS:   m_axis_tready_i <= 1'b1;
        RX_RANDOM:   m_axis_tready_i <= 1'($urandom_range(0, 1));
        RX_PERIODIC: m_axis_tready_i <= (rx_phase % 5) < 3;
        default:     m_axis_tready_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Compare each accepted digest item with the oldest prediction.
  always @(posedge clk_i) begin : check_digest
    digest_item_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest item: word %h index %0d last %0b", $time,
                 m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        err_count++;
      end else begin
        want = digest_q.pop_front();
        if (m_axis_tdata_o !== want.word || m_axis_tuser_o !== want.index ||
            m_axis_tlast_o !== want.last) begin
          $display("%0t: digest mismatch: expected word %h index %0d last %0b, got %h %0d %0b",
                   $time, want.word, want.index, want.last,
                   m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          err_count++;
        end
      end
    end
  end

  // Offer one item in bursts with random gaps, and wait until it is taken.
  task automatic send_item(input logic [7:0] data, input logic has_byte,
                           input logic msg_end);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = steady_send ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tuser_i  <= has_byte;
    s_axis_tlast_i  <= msg_end;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (has_byte || msg_end) items_sent++;
    md5_absorb(data, has_byte, msg_end);
  endtask

  // A message of random bytes; the end rides on the last byte or comes alone.
  task automatic send_message(input int len, input bit noisy);
    int k;
    bit end_on_byte;
    end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (k = 0; k < len; k++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, end_on_byte && (k == len - 1));
    end
    if (!end_on_byte) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Stop offering and wait until every predicted digest item has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  // Extremes of the byte, empty messages, ignored items, both end styles.
  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'haa, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7f, 1'b1, 1'b1);
  endtask

  // Lengths where the pad just fits, where it needs an extra block, and a full block.
  task automatic test_pad_boundaries();
    send_message(55, 1'b0);
    send_message(56, 1'b1);
    send_message(64, 1'b0);
  endtask

  // The receiver holds off while the sender keeps going, so the block backs up.
  task automatic test_backpressure();
    int m;
    hold_off_req = 400;
    steady_send = 1'b1;
    for (m = 0; m < 3; m++) send_message($urandom_range(1, 6), 1'b0);
    steady_send = 1'b0;
    wait_drained();
  endtask

  // Random messages, mostly short, with noise items and drain pauses.
  task automatic test_random(input int item_goal);
    int len;
    item_goal += items_sent;
    while (items_sent < item_goal) begin
      steady_send = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 12);
      send_message(len, 1'b1);
      if ($urandom_range(0, 4) == 0) wait_drained();
    end
    steady_send = 1'b0;
  endtask

  initial begin : main
    int i;
    real s;
    logic [63:0] kv;
    // Round constants from the sine of the step number.
    for (i = 0; i < 64; i++) begin
      s = $sin(i + 1.0);
      if (s < 0.0) s = -s;
      kv = $floor(s * 4294967296.0);
      round_k[i] = kv[31:0];
    end
    for (i = 0; i < 16; i++) msg_block[i] = '0;
    md5_restart();

    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = 8'h00;
    s_axis_tuser_i = 1'b0;
    s_axis_tlast_i = 1'b0;
    m_axis_tready_i = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_pad_boundaries();
    test_backpressure();
    test_random(130);

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("md5_message_digest_tb: clean");
    end else begin
      $display("md5_message_digest_tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
sv/md5_pkg.sv
sv/md5_ctrl.sv
sv/md5_dpath.sv
sv/md5_message_digest.sv
tb/md5_message_digest_tb.sv
